FILE: sv/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// shared widths, codes and sequencer states of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int VALUE_BITS = 32;
   localparam int WIDE_BITS  = 2 * VALUE_BITS;
   localparam int SHIFT_BITS = $clog2(WIDE_BITS);

   typedef logic [VALUE_BITS-1:0] mag_type;
   typedef logic [WIDE_BITS-1:0]  wide_type;
   typedef logic [SHIFT_BITS-1:0] shift_type;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_DIVZERO  = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_LOAD  = 11'b000_0000_0010,
      S_ZTEST = 11'b000_0000_0100,
      S_GCD   = 11'b000_0000_1000,
      S_DIVN  = 11'b000_0001_0000,
      S_DIVD  = 11'b000_0010_0000,
      S_STORE = 11'b000_0100_0000,
      S_MUL   = 11'b000_1000_0000,
      S_SUM   = 11'b001_0000_0000,
      S_CHECK = 11'b010_0000_0000,
      S_DONE  = 11'b100_0000_0000
   } state_type;

endpackage

FILE: sv/rau_gcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_gcd
// binary gcd of two nonzero wide magnitudes, one subtract or shift per cycle
// ----------------------------------------------------------------------------
module rau_gcd (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rau_pkg::wide_type a,
   input  rau_pkg::wide_type b,
   output logic              done,
   output rau_pkg::wide_type g
);
   import rau_pkg::*;

   wide_type  a_ff, a_in, b_ff, b_in, g_ff, g_in;
   shift_type k_ff, k_in;
   logic      run_ff, run_in, done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      g_in    = g_ff;
      k_in    = k_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = a;
         b_in   = b;
         k_in   = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         priority if (a_ff == '0) begin
            g_in    = b_ff << k_ff;
            run_in  = 1'b0;
            done_in = 1'b1;
         end else if (b_ff == '0) begin
            g_in    = a_ff << k_ff;
            run_in  = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      g_ff <= g_in;
      k_ff <= k_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign g    = g_ff;

endmodule

FILE: sv/rau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rau_pkg::wide_type dividend,
   input  rau_pkg::wide_type divisor,
   output logic              done,
   output rau_pkg::wide_type quotient
);
   import rau_pkg::*;

   logic [WIDE_BITS:0] rem_ff, rem_in, trial;
   wide_type           quo_ff, quo_in, den_ff, den_in;
   shift_type          cnt_ff, cnt_in;
   logic               run_ff, run_in, done_ff, done_in, fits;

   always_comb begin
      trial   = {rem_ff[WIDE_BITS-1:0], quo_ff[WIDE_BITS-1]};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? trial - {1'b0, den_ff} : trial;
         quo_in = {quo_ff[WIDE_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SHIFT_BITS'(WIDE_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// fraction add, subtract, multiply and divide with lowest-terms reduction
//
// channel   ports                          handshake
// request   req_command, req_*_numerator,  start & !busy
//           req_*_denominator
// response  rsp_result_*, rsp_status       rsp_valid, one cycle
//
// three reductions run in turn, each a binary gcd then two restoring
// divisions; a zero numerator skips its reduction, and an invalid request
// goes from idle straight to the done state, which raises the response.
// busy stays high from the accepted request until the response strobe.
// reset is synchronous and returns the sequencer to idle.
// the response cannot be stalled.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic signed [31:0] req_left_numerator,
   input  logic signed [31:0] req_left_denominator,
   input  logic signed [31:0] req_right_numerator,
   input  logic signed [31:0] req_right_denominator,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_result_numerator,
   output logic [30:0] rsp_result_denominator,
   output logic [1:0]  rsp_status
);
   import rau_pkg::*;

   function automatic mag_type field_mag(input logic [31:0] f);
      mag_type v;
      v = f[VALUE_BITS-1:0];
      return v[VALUE_BITS-1] ? mag_type'(-v) : v;
   endfunction

   state_type   state_ff, state_in;
   logic [1:0]  phase_ff, phase_in, step_ff, step_in, cmd_ff, cmd_in;
   mag_type     ln_ff, ln_in, ld_ff, ld_in, rn_ff, rn_in, rd_ff, rd_in;
   logic        lns_ff, lns_in, lds_ff, lds_in, rns_ff, rns_in, rds_ff, rds_in;
   wide_type    x_ff, x_in, y_ff, y_in, t1_ff, t1_in, t2_ff, t2_in, dp_ff, dp_in;
   logic        neg_ff, neg_in, bneg;
   mag_type     mul_a, mul_b;
   wide_type    product, limit, negx;
   logic        valid_ff, valid_in;
   logic signed [31:0] onum_ff, onum_in;
   logic [30:0] oden_ff, oden_in;
   logic [1:0]  ost_ff, ost_in;
   logic        gcd_start, gcd_done, div_start, div_done;
   wide_type    gcd_g, div_q, div_dividend;

   rau_gcd u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .a     (x_ff),
      .b     (y_ff),
      .done  (gcd_done),
      .g     (gcd_g)
   );

   assign div_dividend = (state_ff == S_DIVN) ? y_ff : x_ff;

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gcd_g),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      unique case (step_ff)
         2'd0:    begin mul_a = ln_ff; mul_b = (cmd_ff == CMD_MUL) ? rn_ff : rd_ff; end
         2'd1:    begin mul_a = rn_ff; mul_b = ld_ff; end
         default: begin mul_a = ld_ff; mul_b = (cmd_ff == CMD_DIV) ? rn_ff : rd_ff; end
      endcase
      product = WIDE_BITS'(mul_a) * WIDE_BITS'(mul_b);
      limit   = wide_type'(1) << (VALUE_BITS - 1);
      negx    = -x_ff;
      bneg    = ((cmd_ff == CMD_SUB) ? !rns_ff : rns_ff) && (t2_ff != '0);
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      step_in   = step_ff;
      cmd_in    = cmd_ff;
      ln_in     = ln_ff;
      ld_in     = ld_ff;
      rn_in     = rn_ff;
      rd_in     = rd_ff;
      lns_in    = lns_ff;
      lds_in    = lds_ff;
      rns_in    = rns_ff;
      rds_in    = rds_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      neg_in    = neg_ff;
      t1_in     = t1_ff;
      t2_in     = t2_ff;
      dp_in     = dp_ff;
      onum_in   = onum_ff;
      oden_in   = oden_ff;
      ost_in    = ost_ff;
      valid_in  = 1'b0;
      gcd_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_command;
               ln_in    = field_mag(req_left_numerator);
               ld_in    = field_mag(req_left_denominator);
               rn_in    = field_mag(req_right_numerator);
               rd_in    = field_mag(req_right_denominator);
               lns_in   = req_left_numerator[VALUE_BITS-1];
               lds_in   = req_left_denominator[VALUE_BITS-1];
               rns_in   = req_right_numerator[VALUE_BITS-1];
               rds_in   = req_right_denominator[VALUE_BITS-1];
               phase_in = 2'd0;
               onum_in  = '0;
               oden_in  = 31'd1;
               ost_in   = ST_OK;
               if (req_left_denominator[VALUE_BITS-1:0] == '0 ||
                   req_right_denominator[VALUE_BITS-1:0] == '0) begin
                  ost_in   = ST_INVALID;
                  state_in = S_DONE;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            if (phase_ff == 2'd0) begin
               x_in   = WIDE_BITS'(ln_ff);
               y_in   = WIDE_BITS'(ld_ff);
               neg_in = lns_ff ^ lds_ff;
            end else begin
               x_in   = WIDE_BITS'(rn_ff);
               y_in   = WIDE_BITS'(rd_ff);
               neg_in = rns_ff ^ rds_ff;
            end
            state_in = S_ZTEST;
         end
         S_ZTEST: begin
            if (x_ff == '0) begin
               neg_in   = 1'b0;
               y_in     = wide_type'(1);
               state_in = S_STORE;
            end else begin
               gcd_start = 1'b1;
               state_in  = S_GCD;
            end
         end
         S_GCD: begin
            if (gcd_done) begin
               div_start = 1'b1;
               state_in  = S_DIVN;
            end
         end
         S_DIVN: begin
            if (div_done) begin
               x_in      = div_q;
               div_start = 1'b1;
               state_in  = S_DIVD;
            end
         end
         S_DIVD: begin
            if (div_done) begin
               y_in     = div_q;
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            unique case (phase_ff)
               2'd0: begin
                  ln_in    = x_ff[VALUE_BITS-1:0];
                  ld_in    = y_ff[VALUE_BITS-1:0];
                  lns_in   = neg_ff;
                  phase_in = 2'd1;
                  state_in = S_LOAD;
               end
               2'd1: begin
                  rn_in   = x_ff[VALUE_BITS-1:0];
                  rd_in   = y_ff[VALUE_BITS-1:0];
                  rns_in  = neg_ff;
                  step_in = 2'd0;
                  if (cmd_ff == CMD_DIV && x_ff == '0) begin
                     ost_in   = ST_DIVZERO;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_MUL;
                  end
               end
               default: state_in = S_CHECK;
            endcase
         end
         S_MUL: begin
            unique case (step_ff)
               2'd0:    t1_in = product;
               2'd1:    t2_in = product;
               default: dp_in = product;
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            y_in     = dp_ff;
            phase_in = 2'd2;
            state_in = S_ZTEST;
            if (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB) begin
               priority if (lns_ff == bneg) begin
                  x_in   = t1_ff + t2_ff;
                  neg_in = lns_ff;
               end else if (t1_ff >= t2_ff) begin
                  x_in   = t1_ff - t2_ff;
                  neg_in = lns_ff;
               end else begin
                  x_in   = t2_ff - t1_ff;
                  neg_in = bneg;
               end
            end else begin
               x_in   = t1_ff;
               neg_in = lns_ff ^ rns_ff;
            end
         end
         S_CHECK: begin
            if ((neg_ff ? (x_ff > limit) : (x_ff >= limit)) || y_ff >= limit) begin
               ost_in = ST_OVERFLOW;
            end else begin
               onum_in = 32'(signed'(neg_ff ? negx[VALUE_BITS-1:0] : x_ff[VALUE_BITS-1:0]));
               oden_in = 31'(y_ff[VALUE_BITS-2:0]);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      step_ff  <= step_in;
      cmd_ff   <= cmd_in;
      ln_ff    <= ln_in;
      ld_ff    <= ld_in;
      rn_ff    <= rn_in;
      rd_ff    <= rd_in;
      lns_ff   <= lns_in;
      lds_ff   <= lds_in;
      rns_ff   <= rns_in;
      rds_ff   <= rds_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      neg_ff   <= neg_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      dp_ff    <= dp_in;
      onum_ff  <= onum_in;
      oden_ff  <= oden_in;
      ost_ff   <= ost_in;
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy                   = (state_ff != S_IDLE);
   assign rsp_valid              = valid_ff;
   assign rsp_result_numerator   = onum_ff;
   assign rsp_result_denominator = oden_ff;
   assign rsp_status             = ost_ff;

endmodule

FILE: tb/tb_rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// self-checking bench for the rational arithmetic unit
//
// drives directed and random fraction requests in bursts with random gaps,
// predicts each reduced result with a 64-bit sign-magnitude model and
// compares every response strobe against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
   import rau_pkg::*;

   typedef struct {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic [1:0]         status;
   } fraction_result;

   class fraction_scoreboard;
      fraction_result pending[$];
      int errors;

      function longint unsigned euclid(longint unsigned a, longint unsigned b);
         longint unsigned t;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a;
      endfunction

      function void split(logic [31:0] v, output bit neg, output longint unsigned mag);
         neg = v[31];
         mag = neg ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
      endfunction

      function void lowest(ref bit nneg, ref longint unsigned nmag,
                           ref bit dneg, ref longint unsigned dmag);
         longint unsigned g;
         bit neg;
         neg = nneg != dneg;
         dneg = 0;
         if (nmag == 0) begin
            nneg = 0;
            dmag = 1;
         end else begin
            g = euclid(nmag, dmag);
            nmag = nmag / g;
            dmag = dmag / g;
            nneg = neg;
         end
      endfunction

      function void note_request(logic [1:0] cmd, logic [31:0] a, logic [31:0] b,
                                 logic [31:0] c, logic [31:0] d);
         fraction_result r;
         bit ln, ld, rn, rd, n, dn, t1n, t2n;
         longint unsigned lnm, ldm, rnm, rdm, nm, dm, t1, t2;
         longint unsigned lim;
         lim = 64'h8000_0000;
         r.num = 0;
         r.den = 1;
         r.status = ST_OK;
         split(a, ln, lnm);
         split(b, ld, ldm);
         split(c, rn, rnm);
         split(d, rd, rdm);
         if (ldm == 0 || rdm == 0) r.status = ST_INVALID;
         else begin
            lowest(ln, lnm, ld, ldm);
            lowest(rn, rnm, rd, rdm);
            if (cmd == CMD_DIV && rnm == 0) r.status = ST_DIVZERO;
            else begin
               dn = 0;
               if (cmd == CMD_ADD || cmd == CMD_SUB) begin
                  t1n = ln;
                  t1 = lnm * rdm;
                  t2n = (cmd == CMD_SUB) ? !rn : rn;
                  t2 = rnm * ldm;
                  if (t2 == 0) t2n = 0;
                  if (t1n == t2n) begin
                     n = t1n;
                     nm = t1 + t2;
                  end else if (t1 >= t2) begin
                     n = t1n;
                     nm = t1 - t2;
                  end else begin
                     n = t2n;
                     nm = t2 - t1;
                  end
                  if (nm == 0) n = 0;
                  dm = ldm * rdm;
               end else if (cmd == CMD_MUL) begin
                  n = ln != rn;
                  nm = lnm * rnm;
                  dm = ldm * rdm;
               end else begin
                  n = ln != rn;
                  nm = lnm * rdm;
                  dm = ldm * rnm;
               end
               lowest(n, nm, dn, dm);
               if ((n ? nm > lim : nm >= lim) || dm >= lim) r.status = ST_OVERFLOW;
               else begin
                  r.num = n ? -nm[31:0] : nm[31:0];
                  r.den = dm[30:0];
               end
            end
         end
         pending.push_back(r);
      endfunction

      function void check_response(logic signed [31:0] num, logic [30:0] den,
                                   logic [1:0] status);
         fraction_result e;
         if (pending.size() == 0) begin
            $error("unexpected response %0d/%0d status %0d", num, den, status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            errors++;
         end
         if (num !== e.num) begin
            $error("result_numerator: expected %0d, actual %0d", e.num, num);
            errors++;
         end
         if (den !== e.den) begin
            $error("result_denominator: expected %0d, actual %0d", e.den, den);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_command = CMD_ADD;
   logic signed [31:0] req_left_numerator = 0;
   logic signed [31:0] req_left_denominator = 1;
   logic signed [31:0] req_right_numerator = 0;
   logic signed [31:0] req_right_denominator = 1;
   logic rsp_valid;
   logic signed [31:0] rsp_result_numerator;
   logic [30:0] rsp_result_denominator;
   logic [1:0] rsp_status;

   fraction_scoreboard board = new();
   int burst_left = 0;

   always #5 clock = ~clock;

   rational_arithmetic_unit uut (.*);

   always @(posedge clock)
      if (!reset && rsp_valid)
         board.check_response(rsp_result_numerator, rsp_result_denominator, rsp_status);

   task automatic send_request(logic [1:0] cmd, logic [31:0] a, logic [31:0] b,
                               logic [31:0] c, logic [31:0] d);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 30)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      start <= 1;
      req_command <= cmd;
      req_left_numerator <= a;
      req_left_denominator <= b;
      req_right_numerator <= c;
      req_right_denominator <= d;
      do @(posedge clock); while (busy);
      board.note_request(cmd, a, b, c, d);
      burst_left--;
      start <= 0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 20);
         2: return -$urandom_range(1, 20);
         3: return {$urandom_range(0, 3) == 0, 31'd0} + $urandom_range(0, 1);
         4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   initial begin
      logic [31:0] edges[6];
      edges = '{32'h8000_0000, 32'h7fff_ffff, 0, 1, 32'hffff_ffff, 32'h8000_0001};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int c = 0; c < 4; c++) begin
         send_request(2'(c), 1, 2, 1, 3);
         send_request(2'(c), 6, -4, -9, 12);
         send_request(2'(c), edges[0], edges[0], edges[1], edges[4]);
         send_request(2'(c), edges[1], 1, edges[0], 1);
      end
      send_request(CMD_ADD, 5, 0, 1, 1);
      send_request(CMD_DIV, 1, 0, 0, 1);
      send_request(CMD_DIV, 3, 4, 0, -7);
      send_request(CMD_MUL, 0, edges[0], 7, 3);
      send_request(CMD_SUB, 4, 6, 2, 3);
      send_request(CMD_MUL, edges[1], edges[5], edges[1], 1);
      wait (board.pending.size() == 0);
      @(posedge clock);
      for (int i = 0; i < 1330; i++)
         send_request(2'($urandom_range(0, 3)), random_value(), random_value(),
                      random_value(), random_value());
      wait (board.pending.size() == 0);
      repeat (20) @(posedge clock);
      if (board.errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #60ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

FILE: sim.f
sv/rau_pkg.sv
sv/rau_gcd.sv
sv/rau_div.sv
sv/rational_arithmetic_unit.sv
tb/tb_rational_arithmetic_unit.sv
